// ----- src/frame_of_reference_bit_packer_unit_macros.svh -----
// Assertion macros for the frame-of-reference bit packer unit.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef FRAME_OF_REFERENCE_BIT_PACKER_UNIT_MACROS_SVH
`define FRAME_OF_REFERENCE_BIT_PACKER_UNIT_MACROS_SVH
`ifndef SYNTH
// Flag any cycle outside reset in which cond holds.
`define FORBP_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);
// Require cons in the cycle after ante.
`define FORBP_ASSERT_IMPLY_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FORBP_ASSERT_NEVER(lbl, cond, msg)
`define FORBP_ASSERT_IMPLY_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/forbp_pkg.sv -----
// Shared types, constants and helper functions of the bit packer unit.
// No dependencies; imported by every module of the block.
package forbp_pkg;

   localparam int DATA_W      = 64;
   localparam int WIN_W       = 2 * DATA_W;
   localparam int BW_W        = 7;
   localparam int CNT_FIELD_W = 17;
   localparam longint unsigned CNT_FIELD_MAX = 64'd131071;
   localparam int REQ_TDATA_W = 88;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 64;
   localparam longint unsigned MAX_FRAME_VALUES_DEF = 64'd65536;

   // Register indexes (byte address bits [4:3])
   localparam logic [1:0] REG_DIRECTION = 2'd0;
   localparam logic [1:0] REG_BIT_WIDTH = 2'd1;
   localparam logic [1:0] REG_REF_MIN   = 2'd2;

   localparam logic [BW_W-1:0] BW_RESET = 7'd64;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic              direction;
      logic [BW_W-1:0]   bit_width;
      logic [DATA_W-1:0] reference_min;
      logic              clear;
   } cfg_type;

   // Map the raw register to a usable width: zero acts as one, above 64 acts as 64.
   function automatic logic [BW_W-1:0] eff_width(input logic [BW_W-1:0] bw);
      logic [BW_W-1:0] w;
      if (bw == '0) begin
         w = 7'd1;
      end else if (bw > 7'(DATA_W)) begin
         w = 7'(DATA_W);
      end else begin
         w = bw;
      end
      return w;
   endfunction

   function automatic logic [DATA_W-1:0] low_mask(input logic [BW_W-1:0] w);
      logic [DATA_W-1:0] m;
      if (w >= 7'(DATA_W)) begin
         m = '1;
      end else begin
         m = (64'd1 << w) - 64'd1;
      end
      return m;
   endfunction

endpackage

// ----- src/forbp_alu.sv -----
// Shared masked add/subtract unit of the bit packer unit.
// Depends on forbp_pkg.
module forbp_alu (
   input  forbp_pkg::alu_op_type             op,
   input  logic [forbp_pkg::DATA_W-1:0]      a,
   input  logic [forbp_pkg::DATA_W-1:0]      b,
   input  logic [forbp_pkg::BW_W-1:0]        width,
   output logic [forbp_pkg::DATA_W-1:0]      y
);
   import forbp_pkg::*;

   logic [DATA_W-1:0] mask;

   assign mask = low_mask(width);

   // Add: restore a field by masking first. Subtract: mask the offset result.
   always_comb begin
      unique case (op)
         ALU_ADD: y = (a & mask) + b;
         ALU_SUB: y = (a - b) & mask;
      endcase
   end

endmodule

// ----- src/forbp_csr.sv -----
// Configuration register file of the bit packer unit (APB-style port).
// Depends on forbp_pkg.
module forbp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [forbp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [forbp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [forbp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output forbp_pkg::cfg_type                  cfg
);
   import forbp_pkg::*;

   logic              direction_ff;
   logic [BW_W-1:0]   bit_width_ff;
   logic [DATA_W-1:0] ref_min_ff;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         bit_width_ff <= BW_RESET;
         ref_min_ff   <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_DIRECTION: direction_ff <= csr_pwdata[0];
            REG_BIT_WIDTH: bit_width_ff <= csr_pwdata[BW_W-1:0];
            REG_REF_MIN:   ref_min_ff   <= csr_pwdata[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_DIRECTION: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, direction_ff};
         REG_BIT_WIDTH: csr_prdata = {{(CSR_DATA_W-BW_W){1'b0}}, bit_width_ff};
         REG_REF_MIN:   csr_prdata = CSR_DATA_W'(ref_min_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.direction     = direction_ff;
      cfg.bit_width     = bit_width_ff;
      cfg.reference_min = ref_min_ff;
      // Direction and width writes drop all frame state.
      cfg.clear         = wr_en && ((reg_idx == REG_DIRECTION) || (reg_idx == REG_BIT_WIDTH));
   end

endmodule

// ----- src/frame_of_reference_bit_packer_unit.sv -----
// Top level of the frame-of-reference bit packer / unpacker.
// Depends on forbp_pkg, forbp_alu, forbp_csr and the assertion macro header.
//
//   Channel | Ports    | Direction | Carries
//   --------+----------+-----------+------------------------------------------------
//   input   | req_*    | in        | data_word, value_count (tdata), last (tlast)
//   result  | rsp_*    | out       | result_word (tdata), last_out (tlast),
//           |          |           | short_frame (tuser)
//   config  | csr_*    | in/out    | direction @0x00, bit_width @0x08, reference_min @0x10
//
// Steps: pack takes each value through accept, offset subtract and merge, and a flush
//   step when a last value leaves a partial word. Unpack accepts a word, loads the window,
//   then restores up to 64 values with the shared adder, one a cycle while output is free.
// Reset: synchronous; clears control and frame state (payload is not reset), bit_width returns to 64.
// Stalls: req_tready is high only while the sequencer is idle; a full output
//   register with rsp_tready low holds the sequencer in its emit step.
module frame_of_reference_bit_packer_unit #(
   parameter longint unsigned MAX_FRAME_VALUES = forbp_pkg::MAX_FRAME_VALUES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: [63:0] data_word, [80:64] value_count, [87:81] zero
   input  logic [forbp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: [63:0] result_word
   output logic [forbp_pkg::DATA_W-1:0]        rsp_tdata,
   output logic                                rsp_tlast,
   // tuser: [0] short_frame
   output logic [0:0]                          rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [forbp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [forbp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [forbp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import forbp_pkg::*;

`include "frame_of_reference_bit_packer_unit_macros.svh"

   // Counter just wide enough for the saturated frame count.
   localparam int CNT_W = (MAX_FRAME_VALUES >= CNT_FIELD_MAX) ? CNT_FIELD_W :
                          $clog2(MAX_FRAME_VALUES + 64'd1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PACK_SUB,
      S_PACK_MERGE,
      S_PACK_FLUSH,
      S_UNPACK_START,
      S_UNPACK_RUN
   } state_type;

   cfg_type cfg;

   // Sequencer and captured item
   state_type              state_ff, state_in;
   logic [DATA_W-1:0]      in_data_ff, in_data_in;
   logic                   in_last_ff, in_last_in;
   logic [CNT_FIELD_W-1:0] in_count_ff, in_count_in;

   // Pack frame state
   logic [DATA_W-1:0]      v_ff, v_in;
   logic [DATA_W-1:0]      acc_ff, acc_in;
   logic [5:0]             fill_ff, fill_in;

   // Unpack frame state
   logic [WIN_W-1:0]       win_ff, win_in;
   logic [BW_W-1:0]        avail_ff, avail_in;
   logic [DATA_W-1:0]      leftover_ff, leftover_in;
   logic [BW_W-1:0]        lb_ff, lb_in;
   logic [CNT_W-1:0]       remain_ff, remain_in;
   logic                   fstart_ff, fstart_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_short_ff, rsp_short_in;

   // Datapath signals
   logic [BW_W-1:0]        w_eff;
   alu_op_type             alu_op;
   logic [DATA_W-1:0]      alu_a;
   logic [DATA_W-1:0]      alu_y;
   logic [DATA_W-1:0]      shl_src;
   logic [BW_W-1:0]        shl_amt;
   logic [WIN_W-1:0]       shl_out;
   logic [WIN_W-1:0]       win_next;
   logic [BW_W-1:0]        lb_eff;
   logic [BW_W-1:0]        fill_sum;
   logic [BW_W-1:0]        avail_next;
   logic [CNT_W-1:0]       remain_next;
   logic [CNT_W-1:0]       count_sat;
   logic                   out_free;
   logic                   emit;
   logic [DATA_W-1:0]      emit_data;
   logic                   emit_last;
   logic                   emit_short;

   forbp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // One adder serves both directions: subtract on pack, add back on unpack.
   assign alu_op = (state_ff == S_PACK_SUB) ? ALU_SUB : ALU_ADD;
   assign alu_a  = (state_ff == S_PACK_SUB) ? in_data_ff : win_ff[DATA_W-1:0];

   forbp_alu u_alu (
      .op    (alu_op),
      .a     (alu_a),
      .b     (cfg.reference_min),
      .width (w_eff),
      .y     (alu_y)
   );

   assign w_eff = eff_width(cfg.bit_width);

   // One left shifter: places a value at the fill point on pack, or a fresh
   // word above the leftover bits on unpack. The upper half is the spill.
   assign lb_eff  = fstart_ff ? '0 : lb_ff;
   assign shl_src = (state_ff == S_PACK_MERGE) ? v_ff : in_data_ff;
   assign shl_amt = (state_ff == S_PACK_MERGE) ? {1'b0, fill_ff} : lb_eff;
   assign shl_out = {{DATA_W{1'b0}}, shl_src} << shl_amt;

   assign win_next    = win_ff >> w_eff;
   assign avail_next  = avail_ff - w_eff;
   assign remain_next = remain_ff - CNT_W'(1);
   assign fill_sum    = {1'b0, fill_ff} + w_eff;
   assign count_sat   = (64'(in_count_ff) > MAX_FRAME_VALUES) ? CNT_W'(MAX_FRAME_VALUES) :
                                                                CNT_W'(in_count_ff);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      in_data_in   = in_data_ff;
      in_last_in   = in_last_ff;
      in_count_in  = in_count_ff;
      v_in         = v_ff;
      acc_in       = acc_ff;
      fill_in      = fill_ff;
      win_in       = win_ff;
      avail_in     = avail_ff;
      leftover_in  = leftover_ff;
      lb_in        = lb_ff;
      remain_in    = remain_ff;
      fstart_in    = fstart_ff;
      emit         = 1'b0;
      emit_data    = alu_y;
      emit_last    = 1'b0;
      emit_short   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            // Capture the transfer and pick the path by direction.
            if (req_tvalid) begin
               in_data_in  = req_tdata[DATA_W-1:0];
               in_count_in = req_tdata[DATA_W+CNT_FIELD_W-1:DATA_W];
               in_last_in  = req_tlast;
               state_in    = cfg.direction ? S_UNPACK_START : S_PACK_SUB;
            end
         end

         S_PACK_SUB: begin
            v_in     = alu_y;
            state_in = S_PACK_MERGE;
         end

         S_PACK_MERGE: begin
            if (out_free) begin
               if (fill_sum >= 7'(DATA_W)) begin
                  // Word completes: emit it, keep the spill as the new partial word.
                  emit      = 1'b1;
                  emit_data = acc_ff | shl_out[DATA_W-1:0];
                  emit_last = in_last_ff && (fill_sum == 7'(DATA_W));
                  acc_in    = shl_out[WIN_W-1:DATA_W];
                  fill_in   = fill_sum[5:0];
               end else begin
                  acc_in    = acc_ff | shl_out[DATA_W-1:0];
                  fill_in   = fill_sum[5:0];
               end
               state_in = S_IDLE;
               if (in_last_ff) begin
                  if (fill_sum == 7'(DATA_W)) begin
                     // Last value filled the word exactly: nothing left to flush.
                     acc_in  = '0;
                     fill_in = '0;
                  end else begin
                     state_in = S_PACK_FLUSH;
                  end
               end
            end
         end

         S_PACK_FLUSH: begin
            // Emit the zero-padded partial word and close the frame.
            if (out_free) begin
               emit      = 1'b1;
               emit_data = acc_ff;
               emit_last = 1'b1;
               acc_in    = '0;
               fill_in   = '0;
               state_in  = S_IDLE;
            end
         end

         S_UNPACK_START: begin
            if (fstart_ff && (count_sat == '0)) begin
               // Empty frame: consume the word, produce nothing.
               remain_in   = '0;
               lb_in       = '0;
               leftover_in = '0;
               state_in    = S_IDLE;
            end else begin
               if (fstart_ff) begin
                  remain_in = count_sat;
                  fstart_in = 1'b0;
               end
               win_in   = {{DATA_W{1'b0}}, leftover_ff & low_mask(lb_eff)} | shl_out;
               avail_in = 7'(DATA_W) + lb_eff;
               state_in = S_UNPACK_RUN;
            end
         end

         S_UNPACK_RUN: begin
            // Restore one value per cycle, while the output register is free, from the bottom of the window.
            if (out_free) begin
               emit      = 1'b1;
               emit_data = alu_y;
               win_in    = win_next;
               avail_in  = avail_next;
               remain_in = remain_next;
               if (remain_next == '0) begin
                  // Count reached: drop leftover bits, next word starts a frame.
                  emit_last   = 1'b1;
                  leftover_in = '0;
                  lb_in       = '0;
                  fstart_in   = 1'b1;
                  state_in    = S_IDLE;
               end else if (avail_next < w_eff) begin
                  if (in_last_ff) begin
                     // Words ran out before the count: flag a short frame.
                     emit_last   = 1'b1;
                     emit_short  = 1'b1;
                     leftover_in = '0;
                     lb_in       = '0;
                     remain_in   = '0;
                     fstart_in   = 1'b1;
                  end else begin
                     leftover_in = win_next[DATA_W-1:0];
                     lb_in       = avail_next;
                  end
                  state_in = S_IDLE;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase

      // A direction or width write returns all frame state to reset.
      if (cfg.clear) begin
         acc_in      = '0;
         fill_in     = '0;
         leftover_in = '0;
         lb_in       = '0;
         remain_in   = '0;
         fstart_in   = 1'b1;
         state_in    = S_IDLE;
      end
   end

   // Output register: load on emit, drop once the transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_short_in = rsp_short_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
         rsp_last_in  = emit_last;
         rsp_short_in = emit_short;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         fill_ff      <= '0;
         leftover_ff  <= '0;
         lb_ff        <= '0;
         remain_ff    <= '0;
         fstart_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         leftover_ff  <= leftover_in;
         lb_ff        <= lb_in;
         remain_ff    <= remain_in;
         fstart_ff    <= fstart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // Payload: no reset needed
      in_data_ff   <= in_data_in;
      in_last_ff   <= in_last_in;
      in_count_ff  <= in_count_in;
      v_ff         <= v_in;
      win_ff       <= win_in;
      avail_ff     <= avail_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_short_ff <= rsp_short_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_short_ff;

   // Leftover bits never amount to a whole value between words.
   `FORBP_ASSERT_NEVER(a_leftover_below_width, (state_ff == S_IDLE) && (lb_ff >= w_eff), "unpack leftover holds a whole value")
   // An open unpack frame always owes at least one value.
   `FORBP_ASSERT_NEVER(a_open_frame_owes, (state_ff == S_IDLE) && !fstart_ff && (remain_ff == '0), "open unpack frame with zero count")
   // The final owed value goes out flagged last.
   `FORBP_ASSERT_IMPLY_NEXT(a_count_end_last, (state_ff == S_UNPACK_RUN) && out_free && (remain_ff == CNT_W'(1)), rsp_tvalid && rsp_tlast, "final unpack value not flagged last")

endmodule

// ----- test/packer_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the frame-of-reference bit packer unit: mirrors register
// writes, predicts every result transfer and compares the block's output.
// Depends on forbp_pkg for widths, register indexes and reset values.
module packer_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [forbp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [forbp_pkg::DATA_W-1:0]        rsp_tdata,
   input  logic                                rsp_tlast,
   input  logic [0:0]                          rsp_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [forbp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [forbp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   input  logic                                csr_pready,
   output int                                  mismatches,
   output int                                  pending,
   output int                                  words_checked
);

   localparam int FRAME_CAP = int'(forbp_pkg::MAX_FRAME_VALUES_DEF);

   typedef struct packed {
      logic [63:0] word;
      logic        tail;
      logic        truncated;
   } result_item_type;

   result_item_type expected_q[$];

   // mirrored registers
   logic        cfg_unpack;
   logic [6:0]  cfg_width;
   logic [63:0] cfg_offset;

   // pack side
   logic [63:0] acc;
   int          fill;
   // unpack side
   logic [63:0] leftover;
   int          leftover_bits;
   int          remaining;
   logic        at_frame_start;

   function automatic int width_in_use();
      if (cfg_width == 7'd0) return 1;
      if (cfg_width > 7'd64) return 64;
      return int'(cfg_width);
   endfunction

   function automatic logic [63:0] ones_below(input int n);
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
   endfunction

   task automatic clear_frames();
      acc = '0;
      fill = 0;
      leftover = '0;
      leftover_bits = 0;
      remaining = 0;
      at_frame_start = 1'b1;
   endtask

   task automatic pack_value(input logic [63:0] data, input logic lst);
      int          w;
      logic [63:0] v;
      logic [63:0] full;
      logic        have_full;
      w = width_in_use();
      v = (data - cfg_offset) & ones_below(w);
      have_full = 1'b0;
      full = '0;
      if (fill + w >= 64) begin
         full = acc | (v << fill);
         have_full = 1'b1;
         acc = (fill == 0) ? 64'd0 : (v >> (64 - fill));
         fill = fill + w - 64;
      end else begin
         acc = acc | (v << fill);
         fill = fill + w;
      end
      // a full word closes the frame itself when last leaves nothing behind
      if (have_full) expected_q.push_back({full, lst && (fill == 0), 1'b0});
      if (lst) begin
         if (fill > 0) expected_q.push_back({acc, 1'b1, 1'b0});
         acc = '0;
         fill = 0;
      end
   endtask

   task automatic unpack_word(input logic [63:0] word, input logic lst,
                              input logic [16:0] count);
      int              w;
      int              lb;
      int              avail;
      int              n;
      int              i;
      logic [127:0]    window;
      logic [63:0]     mask;
      result_item_type vals[64];
      w = width_in_use();
      lb = leftover_bits;
      mask = ones_below(w);
      n = 0;
      if (lb >= w) lb = 0;
      if (at_frame_start) begin
         remaining = (int'(count) > FRAME_CAP) ? FRAME_CAP : int'(count);
         at_frame_start = 1'b0;
         lb = 0;
         leftover = '0;
      end
      if (remaining == 0) begin
         // zero count: swallow the word, next one opens a frame again
         at_frame_start = 1'b1;
         leftover_bits = 0;
      end else begin
         window = ({64'd0, word} << lb) | {64'd0, leftover & ones_below(lb)};
         avail = 64 + lb;
         while (avail >= w && remaining > 0 && n < 64) begin
            vals[n] = {(window[63:0] & mask) + cfg_offset, 1'b0, 1'b0};
            window = window >> w;
            avail = avail - w;
            remaining = remaining - 1;
            n = n + 1;
         end
         if (remaining == 0) begin
            vals[n-1].tail = 1'b1;
            leftover = '0;
            leftover_bits = 0;
            at_frame_start = 1'b1;
         end else if (lst) begin
            vals[n-1].tail = 1'b1;
            vals[n-1].truncated = 1'b1;
            leftover = '0;
            leftover_bits = 0;
            remaining = 0;
            at_frame_start = 1'b1;
         end else begin
            leftover = window[63:0];
            leftover_bits = avail;
         end
         for (i = 0; i < n; i++) expected_q.push_back(vals[i]);
      end
   endtask

   always @(posedge clock) begin
      result_item_type want;
      if (reset) begin
         cfg_unpack = 1'b0;
         cfg_width = forbp_pkg::BW_RESET;
         cfg_offset = '0;
         clear_frames();
         expected_q.delete();
         mismatches = 0;
         words_checked = 0;
      end else begin
         // retire the output transfer first so a new prediction never matches it
         if (rsp_tvalid && rsp_tready) begin
            words_checked = words_checked + 1;
            if (expected_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected result data=%h last=%b short=%b",
                           $realtime, rsp_tdata, rsp_tlast, rsp_tuser[0]);
               mismatches = mismatches + 1;
            end else begin
               want = expected_q.pop_front();
               if (want.word !== rsp_tdata || want.tail !== rsp_tlast ||
                   want.truncated !== rsp_tuser[0]) begin
                  if (mismatches < 10)
                     $display({"%0t: result mismatch data exp=%h act=%h",
                               " last exp=%b act=%b short exp=%b act=%b"},
                              $realtime, want.word, rsp_tdata, want.tail, rsp_tlast,
                              want.truncated, rsp_tuser[0]);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:3])
               forbp_pkg::REG_DIRECTION: begin
                  cfg_unpack = csr_pwdata[0];
                  clear_frames();
               end
               forbp_pkg::REG_BIT_WIDTH: begin
                  cfg_width = csr_pwdata[6:0];
                  clear_frames();
               end
               forbp_pkg::REG_REF_MIN: begin
                  cfg_offset = csr_pwdata;
               end
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (cfg_unpack)
               unpack_word(req_tdata[63:0], req_tlast, req_tdata[80:64]);
            else
               pack_value(req_tdata[63:0], req_tlast);
         end
      end
      pending = expected_q.size();
   end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Top of the bit packer unit testbench: clock, reset, stimulus and verdict.
// Depends on forbp_pkg, the frame_of_reference_bit_packer_unit RTL and packer_checker.
module tb;

   // Longest unpack word yields 64 values; leave margin on top.
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 90;

   logic                                clock;
   logic                                reset;
   logic [forbp_pkg::REQ_TDATA_W-1:0]   req_tdata;
   logic                                req_tlast;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [forbp_pkg::DATA_W-1:0]        rsp_tdata;
   logic                                rsp_tlast;
   logic [0:0]                          rsp_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [forbp_pkg::CSR_ADDR_W-1:0]    csr_paddr;
   logic [forbp_pkg::CSR_DATA_W-1:0]    csr_pwdata;
   logic [forbp_pkg::CSR_DATA_W-1:0]    csr_prdata;
   logic                                csr_pready;

   int mismatches;
   int pending;
   int words_checked;
   int cycle_count;
   int items_sent;
   int phases;
   int hold_off_cycles;   // one-shot request to the receiver for a long stall
   logic steady;          // no gaps on either side while set

   frame_of_reference_bit_packer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   packer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .mismatches    (mismatches),
      .pending       (pending),
      .words_checked (words_checked)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
         $display("tb NOT OK");
         $finish;
      end
   end

   // Receiver: stall a random number of cycles before each result transfer,
   // or for a long stretch when the stimulus asks for it.
   initial begin : receiver
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = steady ? 0 : $urandom_range(0, 15);
         end
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Register write: setup cycle, then access cycle until pready.
   task automatic program_reg(input logic [1:0] idx, input logic [63:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Offer one input transfer after a random gap; leave valid high on return
   // so a back-to-back item keeps it up without a glitch.
   task automatic offer(input logic [63:0] data, input logic lst, input logic [16:0] count);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {7'd0, count, data};
      req_tlast = lst;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent = items_sent + 1;
   endtask

   // Drop valid, wait for every owed result, then let a word still in
   // flight with no results finish before anything else happens.
   task automatic settle();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic dir, input logic [6:0] bw, input logic [63:0] offset);
      settle();
      program_reg(forbp_pkg::REG_DIRECTION, {63'd0, dir});
      program_reg(forbp_pkg::REG_BIT_WIDTH, {57'd0, bw});
      program_reg(forbp_pkg::REG_REF_MIN, offset);
      phases = phases + 1;
   endtask

   // Pack frame: values near the offset or anywhere, last on the final one;
   // now and then leave the frame open or close it early.
   task automatic pack_frame(input logic [63:0] offset);
      int   n;
      int   i;
      logic open_end;
      logic lst;
      n = $urandom_range(1, 12);
      open_end = ($urandom_range(0, 9) == 0);
      for (i = 0; i < n; i++) begin
         lst = (i == n - 1) ? !open_end : ($urandom_range(0, 19) == 0);
         offer(($urandom_range(0, 3) == 0) ? offset + $urandom_range(0, 255) : random_word(),
               lst, 17'($urandom));
      end
   endtask

   // Unpack frame: mostly well formed, sometimes a zero count, a count the
   // words never reach (short frame) or a surplus word that opens a new frame.
   task automatic unpack_frame(input int w);
      int          kind;
      int          nwords;
      int          cap;
      int          count;
      int          needed;
      int          i;
      logic        lst;
      logic [16:0] field;
      nwords = $urandom_range(1, 4);
      cap = (nwords * 64) / w;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         offer(random_word(), 1'($urandom_range(0, 1)), 17'd0);
      end else if (kind == 1) begin
         field = 17'($urandom_range(cap + 1, 131071));
         for (i = 0; i < nwords; i++)
            offer(random_word(), i == nwords - 1, (i == 0) ? field : 17'($urandom));
      end else begin
         count = $urandom_range(1, cap);
         needed = (count * w + 63) / 64;
         for (i = 0; i < needed; i++) begin
            lst = (i == needed - 1) ? 1'($urandom_range(0, 1)) : 1'b0;
            offer(random_word(), lst, (i == 0) ? 17'(count) : 17'($urandom));
         end
         if (kind == 2) offer(random_word(), 1'b1, 17'($urandom_range(0, cap)));
      end
   endtask

   initial begin : stimulus
      logic        dir;
      logic [6:0]  bw;
      logic [63:0] offset;
      int          w;
      int          frames;
      int          f;
      int          random_start;
      reset = 1'b1;
      req_tdata = '0;
      req_tlast = 1'b0;
      req_tvalid = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cycle_count = 0;
      items_sent = 0;
      phases = 0;
      hold_off_cycles = 0;
      steady = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Reset settings: pack at full width, zero offset; every value is a word.
      offer('1, 1'b0, 17'h1FFFF);
      offer('0, 1'b1, 17'd0);

      // Narrow width with an offset; the value below the offset wraps and is masked.
      configure(1'b0, 7'd3, 64'd5);
      offer(64'd4, 1'b0, 17'd0);
      offer(64'd5, 1'b0, 17'd0);
      offer(64'd12, 1'b1, 17'd0);

      // Width zero acts as one bit.
      configure(1'b0, 7'd0, 64'd0);
      offer(64'd1, 1'b0, 17'd0);
      offer(64'd0, 1'b0, 17'd0);
      offer(64'd1, 1'b1, 17'd0);

      // Width above 64 acts as 64; largest offset.
      configure(1'b0, 7'd127, '1);
      offer('0, 1'b1, 17'd0);

      // Last value exactly fills a word: no empty word after it.
      configure(1'b0, 7'd32, 64'd0);
      offer(random_word(), 1'b0, 17'd0);
      offer(random_word(), 1'b1, 17'd0);

      // Offset write in mid frame keeps the partial word.
      configure(1'b0, 7'd16, 64'd100);
      offer(64'h1234, 1'b0, 17'd0);
      settle();
      program_reg(forbp_pkg::REG_REF_MIN, 64'd7);
      offer(64'h0, 1'b1, 17'd0);

      // Unpack: zero count, count reached early, oversized count cut short,
      // last on a word that also reaches the count.
      configure(1'b1, 7'd8, '1);
      offer(random_word(), 1'b0, 17'd0);
      offer(random_word(), 1'b0, 17'd3);
      offer('1, 1'b1, 17'h1FFFF);
      offer('0, 1'b1, 17'd8);

      // One-bit values: a single word yields the full 64 results.
      configure(1'b1, 7'd1, 64'd0);
      offer('1, 1'b1, 17'd64);

      configure(1'b1, 7'd64, 64'd0);
      offer(random_word(), 1'b0, 17'd2);
      offer(random_word(), 1'b1, 17'd0);

      // Seven-bit values straddle word boundaries.
      configure(1'b1, 7'd7, {$urandom, $urandom});
      offer(random_word(), 1'b0, 17'd20);
      offer(random_word(), 1'b0, 17'd0);
      offer(random_word(), 1'b1, 17'd0);

      configure(1'b1, 7'd0, 64'd0);
      offer(random_word(), 1'b0, 17'd5);
      configure(1'b1, 7'd100, 64'd0);
      offer('0, 1'b0, 17'd1);

      // Back pressure: hold the receiver off while words keep coming, so the
      // block fills and stalls its input; then pause until all results drain.
      configure(1'b1, 7'd1, {$urandom, $urandom});
      steady = 1'b1;
      hold_off_cycles = 400;
      offer(random_word(), 1'b0, 17'd256);
      offer(random_word(), 1'b0, 17'd0);
      offer(random_word(), 1'b0, 17'd0);
      offer(random_word(), 1'b1, 17'd0);
      settle();
      steady = 1'b0;

      // Random phases: a fresh setting, then a few frames in that mode.
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         dir = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0: bw = 7'd1;
            1: bw = 7'd64;
            2: bw = 7'd0;
            3: bw = 7'($urandom_range(65, 127));
            default: bw = 7'($urandom_range(1, 64));
         endcase
         case ($urandom_range(0, 5))
            0: offset = '0;
            1: offset = '1;
            default: offset = {$urandom, $urandom};
         endcase
         configure(dir, bw, offset);
         steady = ($urandom_range(0, 3) == 0);
         w = (bw == 7'd0) ? 1 : ((bw > 7'd64) ? 64 : int'(bw));
         frames = $urandom_range(1, 4);
         for (f = 0; f < frames; f++) begin
            if (dir) unpack_frame(w);
            else pack_frame(offset);
         end
         steady = 1'b0;
      end

      settle();
      $display("covered %0d input transfers over %0d register settings in both directions",
               items_sent, phases);
      $display("checked %0d result transfers, %0d mismatches", words_checked, mismatches);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
